>>> rtl/core/tbwd_pkg.sv
// Package for the TDC bank word deframer: word codes, header geometry and record types.
`timescale 1ns / 1ps
package tbwd_pkg;

	localparam int HeaderWords = 7;
	localparam int StoreDepth  = HeaderWords - 1;
	localparam int PosW        = 3;
	localparam int StoreIdxW   = 3;

	localparam logic [PosW-1:0] BodyPos = PosW'(HeaderWords);

	localparam logic [31:0] FpgaMask  = 32'hfff0_ffff;
	localparam logic [31:0] FpgaMarkA = 32'h0000_0100;
	localparam logic [31:0] FpgaMarkB = 32'h0000_0101;
	localparam logic [31:0] Top3Mask  = 32'he000_0000;
	localparam logic [31:0] EpochCode = 32'h6000_0000;
	localparam logic [31:0] TdcCode   = 32'h8000_0000;

	// What the next body word means.
	typedef enum logic [2:0] {
		MODE_SCAN   = 3'b001,
		MODE_HEADER = 3'b010,
		MODE_CAND   = 3'b100
	} mode_t;

	typedef enum logic {
		REC_MEAS   = 1'b0,
		REC_HEADER = 1'b1
	} rec_kind_t;

	typedef logic [31:0] word_t;

endpackage

>>> rtl/core/tdc_bank_word_deframer.sv
// Top level of the TDC bank word deframer: input stage, bank parser and record register.
`timescale 1ns / 1ps
// Usage:
//   Bank channel (bank_valid / bank_stall): one 32-bit bank word per item,
//   with bank_start on the first word of a bank and bank_end on the last one.
//   Record channel (rec_valid / rec_stall): at most one record per bank word.
//   A header record (record_kind = 1) comes with the seventh word of a bank
//   and carries all seven header words. A measurement record (record_kind = 0)
//   comes with a TDC word (top bits 100) that follows an epoch word and carries
//   the latest FPGA marker, the TDC header word, the epoch and the TDC word.
// Timing:
//   A word enters the input register when it is accepted and is parsed from
//   there; a word that gives a record loads the record register as it moves
//   on. One word per cycle is taken without a gap while bank_stall is low.
// Stall:
//   A valid record holds while rec_stall is high. Words that give no
//   record keep flowing; a word that would give one waits in the input
//   register, and bank_stall rises only then.
// Reset:
//   arst_n clears both valid flags, the header position, the pending mode and
//   the marker, TDC header and epoch words. The first word after reset begins
//   a bank even without bank_start.
module tdc_bank_word_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// bank word channel
	input  logic        bank_valid,
	output logic        bank_stall,
	input  logic [31:0] bank_word,
	input  logic        bank_start,
	input  logic        bank_end,
	// record channel
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic        record_kind,
	output logic [31:0] packet_size,
	output logic [31:0] decoding_word,
	output logic [31:0] board_id,
	output logic [31:0] sequence_number,
	output logic [31:0] run_number,
	output logic [31:0] date_word,
	output logic [31:0] time_word,
	output logic [31:0] fpga_marker_word,
	output logic [31:0] tdc_header_word,
	output logic [31:0] epoch_word,
	output logic [31:0] tdc_word
);

	// Input register
	logic                  vld_s1;
	tbwd_pkg::word_t       word_s1;
	logic                  start_s1;
	logic                  end_s1;

	// Parser state
	logic [tbwd_pkg::PosW-1:0] pos_q;
	tbwd_pkg::mode_t           mode_q;
	tbwd_pkg::word_t           fpga_q;
	tbwd_pkg::word_t           tdc_hdr_q;
	tbwd_pkg::word_t           epoch_q;
	tbwd_pkg::word_t           store_q [tbwd_pkg::StoreDepth];

	// Record register
	logic                  rec_valid_q;
	tbwd_pkg::rec_kind_t   kind_q;
	tbwd_pkg::word_t       hdr_q [tbwd_pkg::HeaderWords];
	tbwd_pkg::word_t       fpga_out_q;
	tbwd_pkg::word_t       tdc_hdr_out_q;
	tbwd_pkg::word_t       epoch_out_q;
	tbwd_pkg::word_t       tdc_out_q;

	// Parse results for the word in the input register
	logic [tbwd_pkg::PosW-1:0] pos_eff;
	tbwd_pkg::mode_t           mode_eff;
	tbwd_pkg::word_t           fpga_eff;
	tbwd_pkg::word_t           tdc_hdr_eff;
	logic [tbwd_pkg::PosW-1:0] pos_nxt;
	tbwd_pkg::mode_t           mode_nxt;
	tbwd_pkg::word_t           fpga_nxt;
	tbwd_pkg::word_t           tdc_hdr_nxt;
	tbwd_pkg::word_t           epoch_nxt;
	logic                      store_we;
	logic                      emit;
	tbwd_pkg::rec_kind_t       emit_kind;
	tbwd_pkg::word_t           fpga_masked;
	logic                      rec_free;
	logic                      go;

	// A start flag clears the bank context before the word is looked at.
	assign pos_eff     = start_s1 ? '0 : pos_q;
	assign mode_eff    = start_s1 ? tbwd_pkg::MODE_SCAN : mode_q;
	assign fpga_eff    = start_s1 ? '0 : fpga_q;
	assign tdc_hdr_eff = start_s1 ? '0 : tdc_hdr_q;
	assign fpga_masked = word_s1 & tbwd_pkg::FpgaMask;

	always_comb begin
		pos_nxt     = pos_eff;
		mode_nxt    = mode_eff;
		fpga_nxt    = fpga_eff;
		tdc_hdr_nxt = tdc_hdr_eff;
		epoch_nxt   = epoch_q;
		store_we    = 1'b0;
		emit        = 1'b0;
		emit_kind   = tbwd_pkg::REC_MEAS;
		priority if (pos_eff < tbwd_pkg::PosW'(tbwd_pkg::StoreDepth)) begin
			// hold header words 0..5
			store_we = 1'b1;
			pos_nxt  = pos_eff + 1'b1;
		end else if (pos_eff < tbwd_pkg::BodyPos) begin
			// seventh header word: give the header record
			emit      = 1'b1;
			emit_kind = tbwd_pkg::REC_HEADER;
			pos_nxt   = tbwd_pkg::BodyPos;
		end else begin
			unique case (mode_eff)
				tbwd_pkg::MODE_HEADER: begin
					tdc_hdr_nxt = word_s1;
					mode_nxt    = tbwd_pkg::MODE_SCAN;
				end
				tbwd_pkg::MODE_CAND: begin
					// drop a candidate that is not a TDC word
					emit     = (word_s1 & tbwd_pkg::Top3Mask) == tbwd_pkg::TdcCode;
					mode_nxt = tbwd_pkg::MODE_SCAN;
				end
				default: begin
					// markers and epoch words open a pair; other words pass without effect
					if (fpga_masked == tbwd_pkg::FpgaMarkA ||
						fpga_masked == tbwd_pkg::FpgaMarkB) begin
						fpga_nxt = word_s1;
						mode_nxt = tbwd_pkg::MODE_HEADER;
					end else if ((word_s1 & tbwd_pkg::Top3Mask) == tbwd_pkg::EpochCode) begin
						epoch_nxt = word_s1;
						mode_nxt  = tbwd_pkg::MODE_CAND;
					end
				end
			endcase
		end
		// An end flag drops any open pair and restarts the bank context.
		if (end_s1) begin
			pos_nxt     = '0;
			mode_nxt    = tbwd_pkg::MODE_SCAN;
			fpga_nxt    = '0;
			tdc_hdr_nxt = '0;
		end
	end

	// Advance the input register unless its word needs a busy record register.
	assign rec_free   = !rec_valid_q || !rec_stall;
	assign go         = vld_s1 && (!emit || rec_free);
	assign bank_stall = vld_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bank_valid && !bank_stall) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bank_valid && !bank_stall) begin
			word_s1  <= bank_word;
			start_s1 <= bank_start;
			end_s1   <= bank_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			mode_q    <= tbwd_pkg::MODE_SCAN;
			fpga_q    <= '0;
			tdc_hdr_q <= '0;
			epoch_q   <= '0;
		end else if (go) begin
			pos_q     <= pos_nxt;
			mode_q    <= mode_nxt;
			fpga_q    <= fpga_nxt;
			tdc_hdr_q <= tdc_hdr_nxt;
			epoch_q   <= epoch_nxt;
		end
	end

	// Header store: no reset, every entry is written before the header record reads it.
	always_ff @(posedge clk) begin
		if (go && store_we) begin
			store_q[pos_eff[tbwd_pkg::StoreIdxW-1:0]] <= word_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (go && emit) begin
			rec_valid_q <= 1'b1;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_q <= emit_kind;
			if (emit_kind == tbwd_pkg::REC_HEADER) begin
				for (int i = 0; i < tbwd_pkg::StoreDepth; i++) begin
					hdr_q[i] <= store_q[i];
				end
				hdr_q[tbwd_pkg::StoreDepth] <= word_s1;
				fpga_out_q    <= '0;
				tdc_hdr_out_q <= '0;
				epoch_out_q   <= '0;
				tdc_out_q     <= '0;
			end else begin
				for (int i = 0; i < tbwd_pkg::HeaderWords; i++) begin
					hdr_q[i] <= '0;
				end
				fpga_out_q    <= fpga_eff;
				tdc_hdr_out_q <= tdc_hdr_eff;
				epoch_out_q   <= epoch_q;
				tdc_out_q     <= word_s1;
			end
		end
	end

	assign rec_valid        = rec_valid_q;
	assign record_kind      = kind_q;
	assign packet_size      = hdr_q[0];
	assign decoding_word    = hdr_q[1];
	assign board_id         = hdr_q[2];
	assign sequence_number  = hdr_q[3];
	assign run_number       = hdr_q[4];
	assign date_word        = hdr_q[5];
	assign time_word        = hdr_q[6];
	assign fpga_marker_word = fpga_out_q;
	assign tdc_header_word  = tdc_hdr_out_q;
	assign epoch_word       = epoch_out_q;
	assign tdc_word         = tdc_out_q;

endmodule

>>> verif/tdc_bank_word_deframer_tb.sv
// Testbench for the TDC bank word deframer: directed and random banks checked against a predictor.
`timescale 1ns / 1ps
module tdc_bank_word_deframer_tb;

	localparam int CLK_PERIOD      = 8;
	localparam int RANDOM_ITEMS    = 1450;
	localparam int DRAIN_CYCLES    = 16;
	localparam int WATCHDOG_CYCLES = 2000;

	// Kinds of shaped body words for the random banks.
	localparam int W_MARK  = 0;
	localparam int W_EPOCH = 1;
	localparam int W_TDC   = 2;
	localparam int W_RAW   = 3;

	// One record as it leaves the block, field for field.
	typedef struct packed {
		tbwd_pkg::rec_kind_t kind;
		tbwd_pkg::word_t     packet_size;
		tbwd_pkg::word_t     decoding;
		tbwd_pkg::word_t     board;
		tbwd_pkg::word_t     seq;
		tbwd_pkg::word_t     run;
		tbwd_pkg::word_t     date;
		tbwd_pkg::word_t     tod;
		tbwd_pkg::word_t     fpga;
		tbwd_pkg::word_t     tdc_hdr;
		tbwd_pkg::word_t     epoch;
		tbwd_pkg::word_t     tdc;
	} rec_t;

	// One row of the directed table; lit marks a record typed in by hand.
	typedef struct packed {
		tbwd_pkg::word_t w;
		logic            s;
		logic            e;
		logic            lit;
		rec_t            want;
	} stim_row_t;

	localparam rec_t NO_REC = '0;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        bank_valid = 1'b0;
	logic        bank_stall;
	logic [31:0] bank_word  = '0;
	logic        bank_start = 1'b0;
	logic        bank_end   = 1'b0;
	logic        rec_valid;
	logic        rec_stall  = 1'b0;
	logic        record_kind;
	logic [31:0] packet_size;
	logic [31:0] decoding_word;
	logic [31:0] board_id;
	logic [31:0] sequence_number;
	logic [31:0] run_number;
	logic [31:0] date_word;
	logic [31:0] time_word;
	logic [31:0] fpga_marker_word;
	logic [31:0] tdc_header_word;
	logic [31:0] epoch_word;
	logic [31:0] tdc_word;

	// Hand-typed record that travels with the item on the bank channel.
	logic lit_on  = 1'b0;
	rec_t lit_rec = '0;

	// Predictor state: a private copy of the deframer's bank tracking.
	logic [tbwd_pkg::PosW-1:0] pos_q;
	tbwd_pkg::mode_t           mode_q;
	tbwd_pkg::word_t           hdr_mem [tbwd_pkg::StoreDepth];
	tbwd_pkg::word_t           fpga_q;
	tbwd_pkg::word_t           tdchdr_q;
	tbwd_pkg::word_t           epoch_q;

	rec_t            pending_recs [$];
	stim_row_t       dir_rows [$];
	tbwd_pkg::word_t bank_buf [$];
	logic [1:0]      flag_buf [$];

	logic mon_hit;
	rec_t mon_rec;
	int   fails      = 0;
	int   items_sent = 0;
	int   recs_taken = 0;
	int   idle_cnt   = 0;
	logic tx_calm    = 1'b0;
	logic rx_calm    = 1'b0;

	tdc_bank_word_deframer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.bank_valid       (bank_valid),
		.bank_stall       (bank_stall),
		.bank_word        (bank_word),
		.bank_start       (bank_start),
		.bank_end         (bank_end),
		.rec_valid        (rec_valid),
		.rec_stall        (rec_stall),
		.record_kind      (record_kind),
		.packet_size      (packet_size),
		.decoding_word    (decoding_word),
		.board_id         (board_id),
		.sequence_number  (sequence_number),
		.run_number       (run_number),
		.date_word        (date_word),
		.time_word        (time_word),
		.fpga_marker_word (fpga_marker_word),
		.tdc_header_word  (tdc_header_word),
		.epoch_word       (epoch_word),
		.tdc_word         (tdc_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Drop back to the top of a bank: header position, pending pair and
	// the marker and TDC header words. The epoch survives on purpose.
	task automatic restart_bank();
		pos_q    = '0;
		mode_q   = tbwd_pkg::MODE_SCAN;
		fpga_q   = '0;
		tdchdr_q = '0;
	endtask

	// Append helpers for the queues.
	task automatic queue_rec(input rec_t r);
		pending_recs.insert(pending_recs.size(), r);
	endtask

	task automatic add_row(input stim_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic add_word(input tbwd_pkg::word_t w);
		bank_buf.insert(bank_buf.size(), w);
	endtask

	task automatic add_flags(input logic [1:0] f);
		flag_buf.insert(flag_buf.size(), f);
	endtask

	// Advance the predictor by one bank word and report the record it causes.
	task automatic deframe_word(input tbwd_pkg::word_t w, input logic s, input logic e,
			output logic hit, output rec_t r);
		tbwd_pkg::word_t masked;
		hit = 1'b0;
		r   = NO_REC;
		if (s) begin
			restart_bank();
		end
		masked = w & tbwd_pkg::FpgaMask;
		if (pos_q < tbwd_pkg::StoreDepth) begin
			// Hold the first six header words.
			hdr_mem[pos_q] = w;
			pos_q          = pos_q + 1'b1;
		end else if (pos_q < tbwd_pkg::BodyPos) begin
			// Seventh word: emit the whole header at once.
			hit           = 1'b1;
			r.kind        = tbwd_pkg::REC_HEADER;
			r.packet_size = hdr_mem[0];
			r.decoding    = hdr_mem[1];
			r.board       = hdr_mem[2];
			r.seq         = hdr_mem[3];
			r.run         = hdr_mem[4];
			r.date        = hdr_mem[5];
			r.tod         = w;
			pos_q         = tbwd_pkg::BodyPos;
		end else if (mode_q == tbwd_pkg::MODE_HEADER) begin
			// Whatever follows a marker is its TDC header.
			tdchdr_q = w;
			mode_q   = tbwd_pkg::MODE_SCAN;
		end else if (mode_q == tbwd_pkg::MODE_CAND) begin
			// Consume the candidate; only top bits 100 make a record.
			if ((w & tbwd_pkg::Top3Mask) == tbwd_pkg::TdcCode) begin
				hit       = 1'b1;
				r.kind    = tbwd_pkg::REC_MEAS;
				r.fpga    = fpga_q;
				r.tdc_hdr = tdchdr_q;
				r.epoch   = epoch_q;
				r.tdc     = w;
			end
			mode_q = tbwd_pkg::MODE_SCAN;
		end else if (masked == tbwd_pkg::FpgaMarkA || masked == tbwd_pkg::FpgaMarkB) begin
			fpga_q = w;
			mode_q = tbwd_pkg::MODE_HEADER;
		end else if ((w & tbwd_pkg::Top3Mask) == tbwd_pkg::EpochCode) begin
			epoch_q = w;
			mode_q  = tbwd_pkg::MODE_CAND;
		end
		if (e) begin
			restart_bank();
		end
	endtask

	task automatic check_field(input string name, input tbwd_pkg::word_t want,
			input tbwd_pkg::word_t got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fails++;
		end
	endtask

	task automatic compare_rec(input rec_t want);
		check_field("record_kind", tbwd_pkg::word_t'(want.kind),
			tbwd_pkg::word_t'(record_kind));
		check_field("packet_size", want.packet_size, packet_size);
		check_field("decoding_word", want.decoding, decoding_word);
		check_field("board_id", want.board, board_id);
		check_field("sequence_number", want.seq, sequence_number);
		check_field("run_number", want.run, run_number);
		check_field("date_word", want.date, date_word);
		check_field("time_word", want.tod, time_word);
		check_field("fpga_marker_word", want.fpga, fpga_marker_word);
		check_field("tdc_header_word", want.tdc_hdr, tdc_header_word);
		check_field("epoch_word", want.epoch, epoch_word);
		check_field("tdc_word", want.tdc, tdc_word);
	endtask

	// Both handshakes are judged here, prediction first, so the order of
	// processes within a time step never matters.
	always @(posedge clk) begin
		if (arst_n && bank_valid && !bank_stall) begin
			deframe_word(bank_word, bank_start, bank_end, mon_hit, mon_rec);
			if (lit_on) begin
				mon_hit = 1'b1;
				mon_rec = lit_rec;
			end
			if (mon_hit) begin
				queue_rec(mon_rec);
			end
		end
		if (arst_n && rec_valid && !rec_stall) begin
			if (pending_recs.size() == 0) begin
				$display("%0t: record expected none got kind %h tdc %h", $time,
					record_kind, tdc_word);
				fails++;
			end else begin
				compare_rec(pending_recs.pop_front());
			end
		end
	end

	// Count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((bank_valid && !bank_stall) || (rec_valid && !rec_stall)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
		if (idle_cnt >= WATCHDOG_CYCLES) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
			$display("tdc_bank_word_deframer test failed");
			$finish;
		end
	end

	// Record side: stall a random number of cycles before taking each item,
	// with calm stretches where records are taken at once.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = rx_calm ? 0 : $urandom_range(0, 7);
			repeat (gap) begin
				@(negedge clk);
				rec_stall = 1'b1;
			end
			@(negedge clk);
			rec_stall = 1'b0;
			do @(posedge clk); while (!rec_valid);
			recs_taken++;
			if (recs_taken % 40 == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Present one bank word after a random gap and hold it until taken.
	task automatic send_word(input tbwd_pkg::word_t w, input logic s, input logic e,
			input logic lit, input rec_t want);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			bank_valid = 1'b0;
		end
		@(negedge clk);
		bank_valid = 1'b1;
		bank_word  = w;
		bank_start = s;
		bank_end   = e;
		lit_on     = lit;
		lit_rec    = want;
		do @(posedge clk); while (bank_stall);
		items_sent++;
	endtask

	// Hold the bank channel until every predicted record has come out.
	task automatic wait_drained();
		@(negedge clk);
		bank_valid = 1'b0;
		lit_on     = 1'b0;
		while (pending_recs.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic tbwd_pkg::word_t shaped_word(input int kind);
		tbwd_pkg::word_t w;
		w = $urandom;
		case (kind)
			W_MARK: w = (w & ~tbwd_pkg::FpgaMask) |
				($urandom_range(0, 1) ? tbwd_pkg::FpgaMarkB : tbwd_pkg::FpgaMarkA);
			W_EPOCH: w = (w & ~tbwd_pkg::Top3Mask) | tbwd_pkg::EpochCode;
			W_TDC: w = (w & ~tbwd_pkg::Top3Mask) | tbwd_pkg::TdcCode;
			default: w = w;
		endcase
		return w;
	endfunction

	// Build one random bank and send it. Most are well formed with random
	// content; the rest are short banks and loose words with stray flags.
	task automatic random_bank();
		int   shape;
		int   n;
		int   k;
		logic use_start;
		logic use_end;
		bank_buf.delete();
		flag_buf.delete();
		shape   = $urandom_range(0, 99);
		tx_calm = ($urandom_range(0, 4) == 0);
		if (shape < 80) begin
			for (k = 0; k < tbwd_pkg::HeaderWords; k++) begin
				add_word($urandom);
			end
			n = $urandom_range(0, 12);
			for (k = 0; k < n; k++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						add_word(shaped_word(W_MARK));
						add_word($urandom);
					end
					2, 3, 4, 5, 6: begin
						add_word(shaped_word(W_EPOCH));
						add_word(shaped_word($urandom_range(0, 6) == 0 ? W_RAW : W_TDC));
					end
					default: add_word(shaped_word($urandom_range(0, 3)));
				endcase
			end
			// Sometimes leave a marker or epoch dangling at the end.
			if ($urandom_range(0, 6) == 0) begin
				add_word(shaped_word($urandom_range(0, 1) ? W_MARK : W_EPOCH));
			end
			use_start = ($urandom_range(0, 9) != 0);
			use_end   = ($urandom_range(0, 6) != 0);
			for (k = 0; k < bank_buf.size(); k++) begin
				add_flags({k == 0 && use_start, k == bank_buf.size() - 1 && use_end});
			end
		end else if (shape < 90) begin
			n = $urandom_range(1, tbwd_pkg::HeaderWords);
			for (k = 0; k < n; k++) begin
				add_word($urandom);
				add_flags({k == 0, k == n - 1});
			end
		end else begin
			n = $urandom_range(4, 16);
			for (k = 0; k < n; k++) begin
				add_word(shaped_word($urandom_range(0, 3)));
				add_flags({$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0});
			end
		end
		for (k = 0; k < bank_buf.size(); k++) begin
			send_word(bank_buf[k], flag_buf[k][1], flag_buf[k][0], 1'b0, NO_REC);
		end
	endtask

	initial begin
		int   i;
		logic pressed;
		pressed = 1'b0;
		restart_bank();
		epoch_q = '0;

		// Directed banks. The first one comes without a start flag, right
		// after reset, and carries extreme header words.
		add_row({32'h0000_0000, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'hffff_ffff, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h1234_5678, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h7fff_ffff, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'hfedc_ba98, 1'b0, 1'b0, 1'b1,
			{tbwd_pkg::REC_HEADER, 32'h0000_0000, 32'hffff_ffff, 32'h1234_5678,
			32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'hfedc_ba98, {4{32'h0}}}});
		// Marker A, then an epoch-looking word that is taken as its TDC header.
		add_row({32'h0000_0100, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h6000_0000, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h6000_0000, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h8000_0000, 1'b0, 1'b0, 1'b1,
			{tbwd_pkg::REC_MEAS, {7{32'h0}}, 32'h0000_0100, 32'h6000_0000,
			32'h6000_0000, 32'h8000_0000}});
		// Marker B with the don't-care nibble set, extreme epoch and TDC word.
		add_row({32'h000f_0101, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'hffff_ffff, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h7fff_ffff, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h9fff_ffff, 1'b0, 1'b0, 1'b1,
			{tbwd_pkg::REC_MEAS, {7{32'h0}}, 32'h000f_0101, 32'hffff_ffff,
			32'h7fff_ffff, 32'h9fff_ffff}});
		// Epoch followed by a bad candidate: consumed and dropped.
		add_row({32'h7fff_fff0, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'ha000_0000, 1'b0, 1'b0, 1'b0, NO_REC});
		// Epoch on the last word: the pair is cut short.
		add_row({32'h6000_0001, 1'b0, 1'b1, 1'b0, NO_REC});
		// Short bank begun by the end flag alone, ending inside its header.
		add_row({32'h8000_0001, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h0000_0100, 1'b0, 1'b0, 1'b0, NO_REC});
		add_row({32'h1111_1111, 1'b0, 1'b1, 1'b0, NO_REC});
		// One-word bank with both flags.
		add_row({32'haaaa_aaaa, 1'b1, 1'b1, 1'b0, NO_REC});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < dir_rows.size(); i++) begin
			send_word(dir_rows[i].w, dir_rows[i].s, dir_rows[i].e, dir_rows[i].lit,
				dir_rows[i].want);
		end

		// Random banks; halfway through, hold off until the record side is empty.
		while (items_sent < RANDOM_ITEMS) begin
			if (!pressed && items_sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				pressed = 1'b1;
			end
			random_bank();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("tdc_bank_word_deframer test passed");
		end else begin
			$display("tdc_bank_word_deframer test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/tbwd_pkg.sv
rtl/core/tdc_bank_word_deframer.sv
verif/tdc_bank_word_deframer_tb.sv
